// File: src/vfr_pkg.sv
package vfr_pkg;

	// Field widths of the request and result channels.
	localparam int unsigned OP_W       = 2;
	localparam int unsigned DT_W       = 16;
	localparam int unsigned ID_W       = 8;
	localparam int unsigned LEVEL_W    = 15;
	localparam int unsigned LEN_W      = 24;
	localparam int unsigned VOL_W      = 10;
	localparam int unsigned CFG_W      = 7;
	localparam int unsigned CFG_IDX_W  = 1;

	// Quotient bits produced by the shared multiply/divide unit.
	localparam int unsigned QUOT_BITS  = 15;

	// Full scale level: 100 percent in 1/256 steps.
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd25600;

	// Gain registers above this value act as this value.
	localparam logic [CFG_W-1:0] GAIN_MAX = 7'd100;

	// Output scaling: floor((2 * L * m * c + 256000) / 512000).
	localparam logic [18:0] VOL_BIAS = 19'd256000;
	localparam logic [18:0] VOL_DIV  = 19'd512000;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MASTER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MUSIC  = 1'b1;

	// Request operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 2'd0,
		OP_PLAY  = 2'd1,
		OP_QUEUE = 2'd2,
		OP_FADE  = 2'd3
	} op_t;

endpackage

// File: src/vfr_if.sv
// Request channel: one command or tick per handshake.
interface vfr_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [vfr_pkg::OP_W-1:0]        op;
	logic [vfr_pkg::DT_W-1:0]        elapsed_ticks;
	logic [vfr_pkg::ID_W-1:0]        track_id;
	logic [vfr_pkg::LEVEL_W-1:0]     target_percent;
	logic [vfr_pkg::LEN_W-1:0]       fade_out_ticks;
	logic [vfr_pkg::LEN_W-1:0]       fade_in_ticks;

	modport source (
		output valid, op, elapsed_ticks, track_id, target_percent, fade_out_ticks,
			fade_in_ticks,
		input  ready
	);
	modport sink (
		input  valid, op, elapsed_ticks, track_id, target_percent, fade_out_ticks,
			fade_in_ticks,
		output ready
	);
endinterface

// Result channel: one volume report per request.
interface vfr_res_if;
	logic                        valid;
	logic                        ready;
	logic [vfr_pkg::VOL_W-1:0]   volume_value;
	logic                        volume_set;
	logic                        start_track;
	logic [vfr_pkg::ID_W-1:0]    started_track_id;
	logic                        fade_active;

	modport source (
		output valid, volume_value, volume_set, start_track, started_track_id, fade_active,
		input  ready
	);
	modport sink (
		input  valid, volume_value, volume_set, start_track, started_track_id, fade_active,
		output ready
	);
endinterface

// File: src/volume_fade_crossfade_ramp.sv
// Background-track volume ramp controller with crossfade on track switch.
// Requests arrive on the cmd channel (valid/ready): a tick with elapsed time,
// play a track, queue a track with fade-out and fade-in, or fade the current
// track. Each request produces exactly one result on the res channel with the
// scaled volume (0..1000), the update and track-start flags and fade status.
// The user must write the gain registers through wr_en/wr_index/wr_data only
// while idle; the block itself does not enforce this. A command, or a tick
// with no running fade, uses the shared multiply/divide unit once, for the
// output scaling; a tick that interpolates inside a running fade uses it
// first for the interpolation and then for the output scaling. The unit
// works one bit per cycle, through 15 multiply steps and then 15 divide steps.
// One request is processed at a time; cmd.ready is high only while idle.
// The result sits in an output register; a stalled receiver holds the result
// and blocks completion of the following request, but that request is still
// accepted and processed up to the output stage.
// Reset initializes the sequencer, ramp, track and gain state: level zero, no track loaded, no fade, gains 100.
module volume_fade_crossfade_ramp #(
	parameter int unsigned TIME_BITS  = 24,
	parameter int unsigned TRACK_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [vfr_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [vfr_pkg::CFG_W-1:0]            wr_data,
	vfr_cmd_if.sink                              cmd,
	vfr_res_if.source                            res
);

	localparam int unsigned LW    = vfr_pkg::LEVEL_W;
	localparam int unsigned QB    = vfr_pkg::QUOT_BITS;
	localparam int unsigned SUM_W = ((TIME_BITS > vfr_pkg::DT_W) ? TIME_BITS
		: vfr_pkg::DT_W) + 1;
	localparam int unsigned MDU_W = (TIME_BITS + 16 > 34) ? TIME_BITS + 16 : 34;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_INTERP,
		S_VOL,
		S_VOLW,
		S_EMIT
	} state_t;

	state_t                        state_q;

	// Latched request.
	vfr_pkg::op_t                  op_q;
	logic [vfr_pkg::DT_W-1:0]      dt_q;
	logic [TRACK_BITS-1:0]         id_q;
	logic [LW-1:0]                 tgt_q;
	logic [vfr_pkg::LEN_W-1:0]     fo_q;
	logic [vfr_pkg::LEN_W-1:0]     fi_q;

	// Ramp and track state.
	logic [LW-1:0]                 level_q;
	logic [LW-1:0]                 start_q;
	logic [LW-1:0]                 target_q;
	logic [TIME_BITS-1:0]          dur_q;
	logic [TIME_BITS-1:0]          elapsed_q;
	logic                          switch_q;
	logic [TRACK_BITS-1:0]         qtrack_q;
	logic [LW-1:0]                 qtarget_q;
	logic [TIME_BITS-1:0]          qfi_q;
	logic [TRACK_BITS-1:0]         playing_q;
	logic                          loaded_q;

	// Gain registers.
	logic [vfr_pkg::CFG_W-1:0]     master_q;
	logic [vfr_pkg::CFG_W-1:0]     music_q;

	// Per-request result flags and the output register.
	logic                          vset_q;
	logic                          started_q;
	logic [TRACK_BITS-1:0]         sid_q;
	logic [vfr_pkg::VOL_W-1:0]     vol_q;
	logic                          res_valid_q;
	logic [vfr_pkg::VOL_W-1:0]     res_vol_q;
	logic                          res_vset_q;
	logic                          res_start_q;
	logic [vfr_pkg::ID_W-1:0]      res_sid_q;
	logic                          res_fade_q;

	// Datapath signals.
	logic [SUM_W-1:0]              e_sum;
	logic [TIME_BITS-1:0]          e_new;
	logic                          ramp_done;
	logic                          up;
	logic [LW-1:0]                 mag;
	logic [LW:0]                   lvl_up;
	logic [LW-1:0]                 lvl_interp;
	logic [TIME_BITS-1:0]          fo_len;
	logic [TIME_BITS-1:0]          fi_len;
	logic [TIME_BITS-1:0]          qfi_len;
	logic [vfr_pkg::CFG_W-1:0]     m_clamp;
	logic [vfr_pkg::CFG_W-1:0]     c_clamp;
	logic [2*vfr_pkg::CFG_W-1:0]   gain;
	logic                          interp_go;
	logic                          emit_ok;

	logic                          mdu_start;
	logic [MDU_W-1:0]              mdu_mcand;
	logic [QB-1:0]                 mdu_mplier;
	logic [MDU_W-1:0]              mdu_bias;
	logic [MDU_W-1:0]              mdu_div;
	logic                          mdu_done;
	logic [QB-1:0]                 mdu_quot;

	// Elapsed time advance with saturation.
	assign e_sum     = SUM_W'(elapsed_q) + SUM_W'(dt_q);
	assign e_new     = (e_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : e_sum[TIME_BITS-1:0];
	assign ramp_done = (e_new >= dur_q);

	// Ramp direction and magnitude, and the interpolated level.
	assign up         = (target_q >= start_q);
	assign mag        = up ? (target_q - start_q) : (start_q - target_q);
	assign lvl_up     = (LW + 1)'(start_q) + (LW + 1)'(mdu_quot);
	assign lvl_interp = up ? ((lvl_up > (LW + 1)'(vfr_pkg::LEVEL_MAX))
		? vfr_pkg::LEVEL_MAX : lvl_up[LW-1:0]) : (start_q - mdu_quot);

	// Fade lengths: a zero length becomes one tick.
	assign fo_len  = (fo_q == '0) ? TIME_BITS'(1) : TIME_BITS'(fo_q);
	assign fi_len  = (fi_q == '0) ? TIME_BITS'(1) : TIME_BITS'(fi_q);
	assign qfi_len = (qfi_q == '0) ? TIME_BITS'(1) : qfi_q;

	// Combined gain, each register clamped to 100.
	assign m_clamp = (master_q > vfr_pkg::GAIN_MAX) ? vfr_pkg::GAIN_MAX : master_q;
	assign c_clamp = (music_q > vfr_pkg::GAIN_MAX) ? vfr_pkg::GAIN_MAX : music_q;
	assign gain    = (2*vfr_pkg::CFG_W)'(m_clamp) * (2*vfr_pkg::CFG_W)'(c_clamp);

	// Multiply/divide requests: interpolation or output scaling.
	assign interp_go  = (op_q == vfr_pkg::OP_TICK) && (dur_q != '0) && !ramp_done;
	assign mdu_start  = ((state_q == S_EXEC) && interp_go) || (state_q == S_VOL);
	assign mdu_mcand  = (state_q == S_VOL) ? MDU_W'(gain) : MDU_W'(e_new);
	assign mdu_mplier = (state_q == S_VOL) ? level_q : mag;
	assign mdu_bias   = (state_q == S_VOL) ? MDU_W'(vfr_pkg::VOL_BIAS) : MDU_W'(dur_q);
	assign mdu_div    = (state_q == S_VOL) ? MDU_W'(vfr_pkg::VOL_DIV)
		: MDU_W'({dur_q, 1'b0});

	vfr_mdu #(
		.W (MDU_W)
	) u_mdu (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mdu_start),
		.mcand   (mdu_mcand),
		.mplier  (mdu_mplier),
		.bias    (mdu_bias),
		.divisor (mdu_div),
		.done    (mdu_done),
		.quot    (mdu_quot)
	);

	// Gain register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= vfr_pkg::GAIN_MAX;
			music_q  <= vfr_pkg::GAIN_MAX;
		end else if (wr_en) begin
			if (wr_index == vfr_pkg::REG_MASTER) begin
				master_q <= wr_data;
			end
			if (wr_index == vfr_pkg::REG_MUSIC) begin
				music_q <= wr_data;
			end
		end
	end

	assign emit_ok = !res_valid_q || res.ready;

	// Request sequencer, ramp state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			level_q     <= '0;
			start_q     <= '0;
			target_q    <= '0;
			dur_q       <= '0;
			elapsed_q   <= '0;
			switch_q    <= 1'b0;
			qtrack_q    <= '0;
			qtarget_q   <= '0;
			qfi_q       <= '0;
			playing_q   <= '0;
			loaded_q    <= 1'b0;
			vset_q      <= 1'b0;
			started_q   <= 1'b0;
			sid_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// The receiver takes the pending result.
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q      <= vfr_pkg::op_t'(cmd.op);
						dt_q      <= cmd.elapsed_ticks;
						id_q      <= TRACK_BITS'(cmd.track_id);
						tgt_q     <= (cmd.target_percent > vfr_pkg::LEVEL_MAX)
							? vfr_pkg::LEVEL_MAX : cmd.target_percent;
						fo_q      <= cmd.fade_out_ticks;
						fi_q      <= cmd.fade_in_ticks;
						vset_q    <= 1'b0;
						started_q <= 1'b0;
						sid_q     <= '0;
						state_q   <= S_EXEC;
					end
				end

				S_EXEC: begin
					state_q <= S_VOL;
					unique case (op_q)
						vfr_pkg::OP_TICK: begin
							if (dur_q != '0) begin
								if (ramp_done) begin
									// Fade reached its end: settle on the target.
									vset_q    <= 1'b1;
									level_q   <= target_q;
									start_q   <= target_q;
									dur_q     <= '0;
									elapsed_q <= '0;
									if (switch_q && (target_q == '0)) begin
										// Fade-out of a switch finished: start the
										// queued track and fade it in.
										playing_q <= qtrack_q;
										loaded_q  <= 1'b1;
										switch_q  <= 1'b0;
										level_q   <= '0;
										start_q   <= '0;
										target_q  <= qtarget_q;
										dur_q     <= qfi_len;
										started_q <= 1'b1;
										sid_q     <= qtrack_q;
									end
								end else begin
									elapsed_q <= e_new;
									state_q   <= S_INTERP;
								end
							end
						end
						vfr_pkg::OP_PLAY: begin
							playing_q <= id_q;
							loaded_q  <= 1'b1;
							switch_q  <= 1'b0;
							elapsed_q <= '0;
							dur_q     <= '0;
							start_q   <= tgt_q;
							target_q  <= tgt_q;
							level_q   <= tgt_q;
							vset_q    <= 1'b1;
							started_q <= 1'b1;
							sid_q     <= id_q;
						end
						vfr_pkg::OP_QUEUE: begin
							if (!loaded_q) begin
								// Nothing playing: start silent and fade in.
								playing_q <= id_q;
								loaded_q  <= 1'b1;
								switch_q  <= 1'b0;
								level_q   <= '0;
								start_q   <= '0;
								target_q  <= tgt_q;
								dur_q     <= fi_len;
								elapsed_q <= '0;
								vset_q    <= 1'b1;
								started_q <= 1'b1;
								sid_q     <= id_q;
							end else if (playing_q == id_q) begin
								start_q   <= level_q;
								target_q  <= tgt_q;
								dur_q     <= fi_len;
								elapsed_q <= '0;
							end else begin
								// Different track: remember it and fade out.
								qtrack_q  <= id_q;
								qfi_q     <= TIME_BITS'(fi_q);
								qtarget_q <= tgt_q;
								switch_q  <= 1'b1;
								start_q   <= level_q;
								target_q  <= '0;
								dur_q     <= fo_len;
								elapsed_q <= '0;
							end
						end
						vfr_pkg::OP_FADE: begin
							start_q   <= level_q;
							target_q  <= tgt_q;
							dur_q     <= fo_len;
							elapsed_q <= '0;
						end
						default: begin
							state_q <= S_VOL;
						end
					endcase
				end

				S_INTERP: begin
					if (mdu_done) begin
						level_q <= lvl_interp;
						vset_q  <= 1'b1;
						state_q <= S_VOL;
					end
				end

				S_VOL: begin
					state_q <= S_VOLW;
				end

				S_VOLW: begin
					if (mdu_done) begin
						vol_q   <= mdu_quot[vfr_pkg::VOL_W-1:0];
						state_q <= S_EMIT;
					end
				end

				S_EMIT: begin
					if (emit_ok) begin
						res_valid_q <= 1'b1;
						res_vol_q   <= vol_q;
						res_vset_q  <= vset_q;
						res_start_q <= started_q;
						res_sid_q   <= vfr_pkg::ID_W'(sid_q);
						res_fade_q  <= (dur_q != '0);
						state_q     <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.ready            = (state_q == S_IDLE);
	assign res.valid            = res_valid_q;
	assign res.volume_value     = res_vol_q;
	assign res.volume_set       = res_vset_q;
	assign res.start_track      = res_start_q;
	assign res.started_track_id = res_sid_q;
	assign res.fade_active      = res_fade_q;

`ifndef SYNTH
	// The shared unit only finishes while the sequencer waits for it.
	a_mdu_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> (state_q == S_INTERP) || (state_q == S_VOLW))
		else $error("multiply/divide result arrived outside a wait state");

	// The level never leaves full scale.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= vfr_pkg::LEVEL_MAX)
		else $error("level above full scale");

	// Elapsed time is cleared whenever no fade runs.
	a_idle_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		(dur_q == '0) |-> (elapsed_q == '0))
		else $error("elapsed time kept without a running fade");

	// A pending switch needs a loaded track.
	a_switch_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		switch_q |-> loaded_q)
		else $error("switch pending with no track loaded");

	// A reported volume stays within the output scale.
	a_volume_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_vol_q <= vfr_pkg::VOL_W'(1000)))
		else $error("volume above 1000");
`endif

endmodule

// File: src/vfr_mdu.sv
// Shared multiply/divide unit. It forms P = mcand * mplier by shift and add,
// one multiplier bit per cycle, then N = 2 * P + bias, and divides N by
// divisor with restoring division, one quotient bit per cycle. The quotient
// must fit in QUOT_BITS bits. A start is ignored while busy; done pulses for
// one cycle with the quotient valid.
module vfr_mdu #(
	parameter int unsigned W = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [W-1:0]                      mcand,
	input  logic [vfr_pkg::QUOT_BITS-1:0]     mplier,
	input  logic [W-1:0]                      bias,
	input  logic [W-1:0]                      divisor,
	output logic                              done,
	output logic [vfr_pkg::QUOT_BITS-1:0]     quot
);

	localparam int unsigned QB    = vfr_pkg::QUOT_BITS;
	localparam int unsigned CNT_W = $clog2(QB);

	typedef enum logic [1:0] {
		P_IDLE,
		P_MUL,
		P_SETUP,
		P_DIV
	} phase_t;

	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [W-1:0]       acc_q;
	logic [W-1:0]       dd_q;
	logic [QB-1:0]      qsr_q;
	logic [W-1:0]       bias_q;
	logic [W-1:0]       div_q;

	// Sequencer and datapath: the accumulator and the shifted operand are
	// shared by the multiply and the divide phases.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				P_IDLE: begin
					if (start) begin
						acc_q   <= '0;
						dd_q    <= mcand;
						qsr_q   <= mplier;
						bias_q  <= bias;
						div_q   <= divisor;
						cnt_q   <= CNT_W'(QB - 1);
						phase_q <= P_MUL;
					end
				end
				P_MUL: begin
					if (qsr_q[0]) begin
						acc_q <= acc_q + dd_q;
					end
					dd_q  <= dd_q << 1;
					qsr_q <= qsr_q >> 1;
					if (cnt_q == '0) begin
						phase_q <= P_SETUP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				P_SETUP: begin
					acc_q   <= {acc_q[W-2:0], 1'b0} + bias_q;
					dd_q    <= div_q << (QB - 1);
					qsr_q   <= '0;
					cnt_q   <= CNT_W'(QB - 1);
					phase_q <= P_DIV;
				end
				P_DIV: begin
					if (acc_q >= dd_q) begin
						acc_q <= acc_q - dd_q;
						qsr_q <= {qsr_q[QB-2:0], 1'b1};
					end else begin
						qsr_q <= {qsr_q[QB-2:0], 1'b0};
					end
					dd_q <= dd_q >> 1;
					if (cnt_q == '0) begin
						phase_q <= P_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					phase_q <= P_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign quot = qsr_q;

endmodule

// File: verif/volume_fade_crossfade_ramp_tb.sv
`timescale 1ns / 100ps

module volume_fade_crossfade_ramp_tb;
	import vfr_pkg::*;

	// Cycles without any handshake before the run is declared hung.
	localparam int unsigned IDLE_LIMIT  = 5000;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 250;
	localparam logic [63:0] TIME_TOP    = 64'hFF_FFFF;

	typedef struct packed {
		op_t                op;
		logic [DT_W-1:0]    elapsed_ticks;
		logic [ID_W-1:0]    track_id;
		logic [LEVEL_W-1:0] target_percent;
		logic [LEN_W-1:0]   fade_out_ticks;
		logic [LEN_W-1:0]   fade_in_ticks;
	} cmd_req_t;

	typedef struct packed {
		logic [VOL_W-1:0] volume_value;
		logic             volume_set;
		logic             start_track;
		logic [ID_W-1:0]  started_track_id;
		logic             fade_active;
	} vol_res_t;

	typedef struct packed {
		cmd_req_t req;
		logic     known;
		vol_res_t want;
	} dir_row_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [CFG_W-1:0] wr_data;

	vfr_cmd_if cmd_ch ();
	vfr_res_if res_ch ();

	volume_fade_crossfade_ramp i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	// Predicted state of the ramp controller and its gain registers.
	logic [LEVEL_W-1:0] lvl_now      = '0;
	logic [LEVEL_W-1:0] ramp_from    = '0;
	logic [LEVEL_W-1:0] ramp_to      = '0;
	logic [63:0]        ramp_len     = '0;
	logic [63:0]        ramp_pos     = '0;
	logic               switch_wait  = 1'b0;
	logic [ID_W-1:0]    next_track   = '0;
	logic [LEVEL_W-1:0] next_level   = '0;
	logic [LEN_W-1:0]   next_fade_in = '0;
	logic [ID_W-1:0]    track_now    = '0;
	logic               track_live   = 1'b0;
	logic [CFG_W-1:0]   gain_master  = GAIN_MAX;
	logic [CFG_W-1:0]   gain_music   = GAIN_MAX;

	vol_res_t volume_expected[$];
	dir_row_t dir_rows[$];

	// Typed-in result for the request currently on the bus, if any.
	logic     row_known = 1'b0;
	vol_res_t row_want  = '0;

	int unsigned fail_count  = 0;
	int unsigned items_sent  = 0;
	int unsigned burst_left  = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_mode     = 0;
	int unsigned rx_left     = 0;
	int unsigned rx_count    = 0;

	int unsigned master_plan[PHASES] = '{100, 0, 127, 1, 55, 101, 100, 0};
	int unsigned music_plan[PHASES]  = '{100, 100, 0, 127, 99, 100, 1, 0};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [63:0] v);
		return (v > LEVEL_MAX) ? LEVEL_MAX : v[LEVEL_W-1:0];
	endfunction

	function automatic void start_ramp(input logic [LEVEL_W-1:0] to, input logic [LEN_W-1:0] len);
		ramp_from = lvl_now;
		ramp_to = clamp_level(to);
		ramp_len = (len == 0) ? 64'd1 : len;
		ramp_pos = '0;
	endfunction

	function automatic void load_track(input logic [ID_W-1:0] id, input logic [LEVEL_W-1:0] level);
		track_now = id;
		track_live = 1'b1;
		switch_wait = 1'b0;
		ramp_pos = '0;
		ramp_len = '0;
		ramp_from = level;
		ramp_to = level;
		lvl_now = level;
	endfunction

	// Advances the predicted state by one request and returns the volume report.
	function automatic vol_res_t predict_volume(input cmd_req_t r);
		vol_res_t           o;
		logic [LEVEL_W-1:0] tgt;
		logic [63:0]        span;
		logic [63:0]        quot;
		logic [63:0]        gm;
		logic [63:0]        gc;
		logic               rising;
		o = '0;
		tgt = clamp_level(r.target_percent);
		case (r.op)
			OP_TICK: begin
				if (ramp_len != 0) begin
					ramp_pos = ramp_pos + r.elapsed_ticks;
					if (ramp_pos > TIME_TOP)
						ramp_pos = TIME_TOP;
					if (ramp_pos >= ramp_len) begin
						lvl_now = ramp_to;
					end else begin
						rising = ramp_to >= ramp_from;
						span = rising ? ramp_to - ramp_from : ramp_from - ramp_to;
						quot = (span * ramp_pos * 2 + ramp_len) / (ramp_len * 2);
						lvl_now = clamp_level(rising ? ramp_from + quot : ramp_from - quot);
					end
					o.volume_set = 1'b1;
					// A finished fade-out to silence hands over to the queued track.
					if (ramp_pos >= ramp_len) begin
						ramp_len = '0;
						ramp_pos = '0;
						ramp_from = lvl_now;
						if (switch_wait && lvl_now == 0) begin
							load_track(next_track, '0);
							start_ramp(next_level, next_fade_in);
							o.start_track = 1'b1;
							o.started_track_id = next_track;
						end
					end
				end
			end
			OP_PLAY: begin
				load_track(r.track_id, tgt);
				o.volume_set = 1'b1;
				o.start_track = 1'b1;
				o.started_track_id = r.track_id;
			end
			OP_QUEUE: begin
				if (!track_live) begin
					load_track(r.track_id, '0);
					start_ramp(tgt, r.fade_in_ticks);
					o.volume_set = 1'b1;
					o.start_track = 1'b1;
					o.started_track_id = r.track_id;
				end else if (track_now == r.track_id) begin
					start_ramp(tgt, r.fade_in_ticks);
				end else begin
					next_track = r.track_id;
					next_fade_in = r.fade_in_ticks;
					next_level = tgt;
					switch_wait = 1'b1;
					start_ramp('0, r.fade_out_ticks);
				end
			end
			default: begin
				start_ramp(tgt, r.fade_out_ticks);
			end
		endcase
		gm = (gain_master > GAIN_MAX) ? GAIN_MAX : gain_master;
		gc = (gain_music > GAIN_MAX) ? GAIN_MAX : gain_music;
		o.volume_value = (lvl_now * gm * gc * 2 + VOL_BIAS) / VOL_DIV;
		o.fade_active = ramp_len != 0;
		return o;
	endfunction

	function automatic cmd_req_t rand_req();
		cmd_req_t r;
		r.op = op_t'($urandom_range(0, 3));
		r.elapsed_ticks = $urandom;
		r.track_id = $urandom;
		r.target_percent = $urandom;
		r.fade_out_ticks = $urandom;
		r.fade_in_ticks = $urandom;
		return r;
	endfunction

	// Levels lean on silence, full scale and the clamped range above it.
	function automatic logic [LEVEL_W-1:0] rand_level();
		logic [LEVEL_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = LEVEL_MAX;
			2: v = $urandom_range(25601, 32767);
			default: v = $urandom_range(0, 25600);
		endcase
		return v;
	endfunction

	// Mostly short fades so that ticks get through them.
	function automatic logic [LEN_W-1:0] rand_len();
		logic [LEN_W-1:0] v;
		case ($urandom_range(0, 19))
			0, 1: v = '0;
			2: v = $urandom;
			3, 4: v = $urandom_range(1, 5000);
			default: v = $urandom_range(1, 300);
		endcase
		return v;
	endfunction

	function automatic logic [DT_W-1:0] rand_dt();
		logic [DT_W-1:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1: v = $urandom;
			2, 3: v = $urandom_range(1, 2000);
			default: v = $urandom_range(1, 80);
		endcase
		return v;
	endfunction

	// Picks the playing track now and then, otherwise a different one.
	function automatic logic [ID_W-1:0] pick_track();
		logic [ID_W-1:0] id;
		id = $urandom;
		if (track_live) begin
			if ($urandom_range(0, 9) < 2)
				id = track_now;
			else if (id == track_now)
				id = id + 1'b1;
		end
		return id;
	endfunction

	task automatic add_row(input op_t op, input logic [DT_W-1:0] dt,
			input logic [ID_W-1:0] id, input logic [LEVEL_W-1:0] tgt,
			input logic [LEN_W-1:0] fo, input logic [LEN_W-1:0] fi, input logic known,
			input logic [VOL_W-1:0] vol, input logic vset, input logic st,
			input logic [ID_W-1:0] sid, input logic fa);
		dir_row_t row;
		row.req = '{op, dt, id, tgt, fo, fi};
		row.known = known;
		row.want = '{vol, vset, st, sid, fa};
		dir_rows.push_back(row);
	endtask

	// Presents one request in bursts with random gaps; returns at the falling
	// edge after it was taken.
	task automatic send_item(input cmd_req_t r, input logic known, input vol_res_t want);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
			if (gap != 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left = burst_left - 1;
		row_known = known;
		row_want = want;
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= r.op;
		cmd_ch.elapsed_ticks <= r.elapsed_ticks;
		cmd_ch.track_id <= r.track_id;
		cmd_ch.target_percent <= r.target_percent;
		cmd_ch.fade_out_ticks <= r.fade_out_ticks;
		cmd_ch.fade_in_ticks <= r.fade_in_ticks;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		items_sent = items_sent + 1;
		@(negedge clk);
	endtask

	// Ticks a running fade until it ends or max_items requests are sent, with an occasional new fade in between.
	task automatic follow_ramp(input int unsigned fade_pct, input int unsigned max_items,
			input logic full_dt);
		cmd_req_t    r;
		int unsigned n;
		n = 0;
		while (ramp_len != 0 && n < max_items) begin
			r = rand_req();
			if ($urandom_range(0, 99) < fade_pct) begin
				r.op = OP_FADE;
				r.target_percent = rand_level();
				r.fade_out_ticks = rand_len();
			end else begin
				r.op = OP_TICK;
				r.elapsed_ticks = full_dt ? {DT_W{1'b1}} : rand_dt();
			end
			send_item(r, 1'b0, '0);
			n = n + 1;
		end
	endtask

	// Stops requests and lets every outstanding result drain.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (volume_expected.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_gains(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] c);
		wr_en <= 1'b1;
		wr_index <= REG_MASTER;
		wr_data <= m;
		@(negedge clk);
		wr_index <= REG_MUSIC;
		wr_data <= c;
		@(negedge clk);
		wr_en <= 1'b0;
		gain_master = m;
		gain_music = c;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count = fail_count + 1;
		end
	endtask

	// Every accepted request yields one expected result.
	always @(posedge clk) begin : request_track
		cmd_req_t r;
		vol_res_t p;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			r.op = op_t'(cmd_ch.op);
			r.elapsed_ticks = cmd_ch.elapsed_ticks;
			r.track_id = cmd_ch.track_id;
			r.target_percent = cmd_ch.target_percent;
			r.fade_out_ticks = cmd_ch.fade_out_ticks;
			r.fade_in_ticks = cmd_ch.fade_in_ticks;
			p = predict_volume(r);
			volume_expected.push_back(row_known ? row_want : p);
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : result_check
		vol_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (volume_expected.size() == 0) begin
				$error("result with no request outstanding: volume_value %0d",
					res_ch.volume_value);
				fail_count = fail_count + 1;
			end else begin
				want = volume_expected.pop_front();
				check_field("volume_value", want.volume_value, res_ch.volume_value);
				check_field("volume_set", want.volume_set, res_ch.volume_set);
				check_field("start_track", want.start_track, res_ch.start_track);
				check_field("started_track_id", want.started_track_id,
					res_ch.started_track_id);
				check_field("fade_active", want.fade_active, res_ch.fade_active);
			end
		end
	end

	// The receiver switches between free flow, random stalls and long stalls.
	always @(negedge clk) begin
		rx_count <= rx_count + 1;
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 400);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: res_ch.ready <= 1'b1;
			1: res_ch.ready <= ($urandom_range(0, 3) != 0);
			2: res_ch.ready <= ($urandom_range(0, 4) == 0);
			default: res_ch.ready <= (rx_count % 24) >= 20;
		endcase
	end

	// Watchdog on handshake activity.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cmd_req_t    r;
		dir_row_t    row;
		int unsigned pick;
		int unsigned phase_end;
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_MASTER;
		wr_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_TICK;
		cmd_ch.elapsed_ticks = '0;
		cmd_ch.track_id = '0;
		cmd_ch.target_percent = '0;
		cmd_ch.fade_out_ticks = '0;
		cmd_ch.fade_in_ticks = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests at reset gains; typed results where they are obvious.
		add_row(OP_TICK, 16'hFFFF, 8'hFF, 15'h7FFF, 24'hFFFFFF, 24'hFFFFFF, 1, 0, 0, 0, 0, 0);
		add_row(OP_QUEUE, 0, 8'hFF, 15'h7FFF, 0, 0, 1, 0, 1, 1, 8'hFF, 1);
		add_row(OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 1, 0, 0, 0, 0, 1, 1000, 1, 0, 0, 0);
		add_row(OP_TICK, 0, 0, 0, 0, 0, 1, 1000, 0, 0, 0, 0);
		add_row(OP_PLAY, 0, 8'h00, 0, 0, 0, 1, 0, 1, 1, 8'h00, 0);
		add_row(OP_PLAY, 0, 8'hAA, 25600, 0, 0, 1, 1000, 1, 1, 8'hAA, 0);
		add_row(OP_FADE, 0, 0, 0, 24'hFFFFFF, 0, 1, 1000, 0, 0, 0, 1);
		add_row(OP_TICK, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_FADE, 0, 0, 12800, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 16'hFFFF, 0, 0, 0, 0, 1, 500, 1, 0, 0, 0);
		add_row(OP_QUEUE, 0, 8'hAA, 25600, 5, 100, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 50, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_QUEUE, 0, 8'h55, 20000, 10, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_FADE, 0, 0, 15'h7FFF, 20, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 20, 0, 0, 0, 0, 1, 1000, 1, 0, 0, 0);
		add_row(OP_FADE, 0, 0, 0, 5, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 2, 0, 0, 0, 0, 1, 0, 1, 1, 8'h55, 1);
		add_row(OP_TICK, 1, 0, 0, 0, 0, 1, 781, 1, 0, 0, 0);
		add_row(OP_QUEUE, 0, 8'h01, 100, 100, 24'hFFFFFF, 0, 0, 0, 0, 0, 0);
		add_row(OP_PLAY, 0, 8'h02, 1000, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_QUEUE, 0, 8'h02, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 1, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0);
		while (dir_rows.size() != 0) begin
			row = dir_rows.pop_front();
			send_item(row.req, row.known, row.want);
		end

		// Random phases, each under its own gain setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			if (ph == PHASES - 1)
				write_gains($urandom_range(0, 127), $urandom_range(0, 127));
			else
				write_gains(master_plan[ph], music_plan[ph]);
			phase_end = items_sent + PHASE_ITEMS;
			// A maximal fade ticked at full step drives elapsed time into saturation.
			if (ph == 2 || ph == 5) begin
				r = rand_req();
				r.op = OP_FADE;
				r.target_percent = rand_level();
				r.fade_out_ticks = 24'hFFFFFF - $urandom_range(0, 255);
				send_item(r, 1'b0, '0);
				follow_ramp(0, 300, 1'b1);
			end
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				r = rand_req();
				if (pick < 40) begin
					r.op = OP_QUEUE;
					r.track_id = pick_track();
					r.target_percent = rand_level();
					r.fade_out_ticks = rand_len();
					r.fade_in_ticks = rand_len();
					send_item(r, 1'b0, '0);
					follow_ramp(8, 80, 1'b0);
				end else if (pick < 55) begin
					r.op = OP_FADE;
					r.target_percent = rand_level();
					r.fade_out_ticks = rand_len();
					send_item(r, 1'b0, '0);
					follow_ramp(0, 80, 1'b0);
				end else if (pick < 70) begin
					r.op = OP_PLAY;
					r.target_percent = rand_level();
					send_item(r, 1'b0, '0);
				end else begin
					send_item(r, 1'b0, '0);
				end
			end
		end

		// Drain and allow a late stray result to show up.
		cmd_ch.valid <= 1'b0;
		while (volume_expected.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
